// File: hw/rtl/char_lcd_nibble_write_sequencer_defines.svh
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define LCDSEQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdseq: check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define LCDSEQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdseq: check failed");

`endif

// File: hw/rtl/lcdseq_pkg.sv
package lcdseq_pkg;

  localparam int unsigned PC_W = 6;

  localparam logic [1:0] CMD_WRITE_CMD  = 2'd0;
  localparam logic [1:0] CMD_WRITE_DATA = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;
  localparam logic [1:0] CMD_INIT       = 2'd3;

  localparam logic [2:0] CFG_ENABLE_PULSE   = 3'd0;
  localparam logic [2:0] CFG_NIBBLE_GAP     = 3'd1;
  localparam logic [2:0] CFG_COMMAND_SETTLE = 3'd2;
  localparam logic [2:0] CFG_DATA_SETTLE    = 3'd3;
  localparam logic [2:0] CFG_POWER_ON_WAIT  = 3'd4;

  // Program layout: one byte routine, the clear routine, the init routine.
  localparam logic [PC_W-1:0] PC_BYTE  = 6'd0;
  localparam logic [PC_W-1:0] PC_CLEAR = 6'd4;
  localparam logic [PC_W-1:0] PC_INIT  = 6'd12;
  localparam logic [PC_W-1:0] PC_LAST  = 6'd40;

  localparam logic [7:0] CLEAR_BYTE_0 = 8'h01;
  localparam logic [7:0] CLEAR_BYTE_1 = 8'h02;
  localparam logic [7:0] INIT_BYTES [7] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h02};
  localparam logic [7:0] HI_MASK = 8'hF0;
  localparam logic [7:0] LO_MASK = 8'h0F;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_value;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_select;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] enable_pulse_us;
    logic [15:0] nibble_gap_us;
    logic [15:0] command_settle_us;
    logic [15:0] data_settle_us;
    logic [15:0] power_on_wait_us;
  } cfg_t;

  typedef enum logic [1:0] {NIB_ZERO, NIB_HI, NIB_LO} nib_sel_t;
  typedef enum logic [1:0] {HOLD_PULSE, HOLD_GAP, HOLD_SETTLE, HOLD_POWER} hold_sel_t;

  typedef struct packed {
    nib_sel_t   nib_sel;
    logic       byte_from_item;
    logic [7:0] byte_const;
    logic       rs_from_item;
    logic       enable;
    hold_sel_t  hold_sel;
    logic       last;
  } ucode_t;

  function automatic ucode_t byte_step(input logic [1:0] phase, input logic from_item,
                                       input logic [7:0] byte_const);
    ucode_t w;
    w.nib_sel        = phase[1] ? NIB_LO : NIB_HI;
    w.byte_from_item = from_item;
    w.byte_const     = byte_const;
    w.rs_from_item   = from_item;
    w.enable         = ~phase[0];
    w.hold_sel       = phase[0] ? (phase[1] ? HOLD_SETTLE : HOLD_GAP) : HOLD_PULSE;
    w.last           = 1'b0;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t          w;
    logic [PC_W-1:0] rel;
    if (pc < PC_CLEAR) begin
      w      = byte_step(pc[1:0], 1'b1, 8'h00);
      w.last = (pc == PC_CLEAR - 6'd1);
    end else if (pc < PC_INIT) begin
      rel    = pc - PC_CLEAR;
      w      = byte_step(rel[1:0], 1'b0, rel[2] ? CLEAR_BYTE_1 : CLEAR_BYTE_0);
      w.last = (pc == PC_INIT - 6'd1);
    end else if (pc == PC_INIT) begin
      w.nib_sel        = NIB_ZERO;
      w.byte_from_item = 1'b0;
      w.byte_const     = 8'h00;
      w.rs_from_item   = 1'b0;
      w.enable         = 1'b0;
      w.hold_sel       = HOLD_POWER;
      w.last           = 1'b0;
    end else if (pc <= PC_LAST) begin
      rel    = pc - (PC_INIT + 6'd1);
      w      = byte_step(rel[1:0], 1'b0, INIT_BYTES[rel[4:2]]);
      w.last = (pc == PC_LAST);
    end else begin
      w      = byte_step(2'd0, 1'b0, 8'h00);
      w.last = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [1:0] cmd);
    logic [PC_W-1:0] pc;
    case (cmd)
      CMD_WRITE_CMD, CMD_WRITE_DATA: pc = PC_BYTE;
      CMD_CLEAR:                     pc = PC_CLEAR;
      default:                       pc = PC_INIT;
    endcase
    return pc;
  endfunction

endpackage

// File: hw/rtl/lcdseq_cfg.sv
module lcdseq_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output lcdseq_pkg::cfg_t  cfg
);

  lcdseq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_us   <= 16'd1;
      cfg_r.nibble_gap_us     <= 16'd50;
      cfg_r.command_settle_us <= 16'd2000;
      cfg_r.data_settle_us    <= 16'd1000;
      cfg_r.power_on_wait_us  <= 16'd20000;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdseq_pkg::CFG_ENABLE_PULSE:   cfg_r.enable_pulse_us   <= cfg_wdata;
        lcdseq_pkg::CFG_NIBBLE_GAP:     cfg_r.nibble_gap_us     <= cfg_wdata;
        lcdseq_pkg::CFG_COMMAND_SETTLE: cfg_r.command_settle_us <= cfg_wdata;
        lcdseq_pkg::CFG_DATA_SETTLE:    cfg_r.data_settle_us    <= cfg_wdata;
        lcdseq_pkg::CFG_POWER_ON_WAIT:  cfg_r.power_on_wait_us  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hw/rtl/lcdseq_useq.sv
`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcdseq_useq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdseq_pkg::cfg_t       cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcdseq_pkg::in_beat_t   in_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lcdseq_pkg::out_beat_t  out_beat
);

  logic                          busy_r;
  logic [lcdseq_pkg::PC_W-1:0]   pc_r;
  lcdseq_pkg::in_beat_t          item_r;
  logic                          out_valid_r;
  lcdseq_pkg::out_beat_t         out_beat_r;

  lcdseq_pkg::ucode_t            word;
  logic                          accept;
  logic                          issue;
  logic [7:0]                    cur_byte;
  logic                          rs;
  lcdseq_pkg::out_beat_t         out_beat_nxt;

  assign word     = lcdseq_pkg::ucode_rom(pc_r);
  assign in_ready = ~busy_r;
  assign accept   = in_valid & in_ready;
  assign issue    = busy_r & (~out_valid_r | out_ready);

  always_comb begin
    cur_byte = word.byte_from_item ? item_r.byte_value : word.byte_const;
    rs       = word.rs_from_item & (item_r.cmd == lcdseq_pkg::CMD_WRITE_DATA);
    case (word.nib_sel)
      lcdseq_pkg::NIB_HI: out_beat_nxt.nibble = 4'((cur_byte & lcdseq_pkg::HI_MASK) >> 4);
      lcdseq_pkg::NIB_LO: out_beat_nxt.nibble = 4'(cur_byte & lcdseq_pkg::LO_MASK);
      default:            out_beat_nxt.nibble = 4'd0;
    endcase
    case (word.hold_sel)
      lcdseq_pkg::HOLD_PULSE:  out_beat_nxt.hold_us = cfg.enable_pulse_us;
      lcdseq_pkg::HOLD_GAP:    out_beat_nxt.hold_us = cfg.nibble_gap_us;
      lcdseq_pkg::HOLD_SETTLE: out_beat_nxt.hold_us = rs ? cfg.data_settle_us
                                                         : cfg.command_settle_us;
      default:                 out_beat_nxt.hold_us = cfg.power_on_wait_us;
    endcase
    out_beat_nxt.reg_select = rs;
    out_beat_nxt.enable     = word.enable;
    out_beat_nxt.last       = word.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
        pc_r   <= lcdseq_pkg::entry_pc(in_beat.cmd);
        item_r <= in_beat;
      end else if (issue) begin
        if (word.last) begin
          busy_r <= 1'b0;
        end else begin
          pc_r <= pc_r + 6'd1;
        end
      end
      if (issue) begin
        out_valid_r <= 1'b1;
        out_beat_r  <= out_beat_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `LCDSEQ_ASSERT_NXT(a_accept_starts, accept, busy_r)
  `LCDSEQ_ASSERT_NXT(a_last_ends, issue && word.last, !busy_r)
  `LCDSEQ_ASSERT_NXT(a_step_advances, issue && !word.last, busy_r && pc_r == $past(pc_r) + 6'd1)
  `LCDSEQ_ASSERT_IMP(a_pc_in_program, busy_r, pc_r <= lcdseq_pkg::PC_LAST)

endmodule

// File: hw/rtl/char_lcd_nibble_write_sequencer.sv
// Turns one request into the timed pin phases of a character LCD on a 4-bit bus, one phase
// per result beat. A command or data write gives 4 phases, a clear gives 8 and an init gives
// 29 (a power-on wait, then seven command bytes). Once a request is taken, its phases
// leave at one per cycle while out_ready is high; the step counter of the microprogram
// issues one control word per cycle unless the output is stalled, and sets this pace.
// The next request is taken in the cycle after the last phase is issued, while
// that phase may still wait in the output register. Timing registers may be written only
// while no request is in progress.
module char_lcd_nibble_write_sequencer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcdseq_pkg::in_beat_t   in_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lcdseq_pkg::out_beat_t  out_beat,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_wdata
);

  lcdseq_pkg::cfg_t cfg;

  lcdseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_FIRST_SPARE = 3'd5;
  localparam logic [2:0] CFG_LAST_SPARE  = 3'd7;
  localparam int         DIR_ROWS        = 12;
  localparam int         PHASES          = 8;
  localparam int         ITEMS_PER_PHASE = 45;

  typedef struct packed {
    lcdseq_pkg::in_beat_t             beat;
    logic                             typed;
    lcdseq_pkg::out_beat_t [0:3]      want_ph;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  lcdseq_pkg::in_beat_t  in_beat;
  logic                  out_valid;
  logic                  out_ready;
  lcdseq_pkg::out_beat_t out_beat;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [15:0]           cfg_wdata;

  lcdseq_pkg::cfg_t      timing;
  lcdseq_pkg::out_beat_t pending_phases[$];
  lcdseq_pkg::out_beat_t want;
  dir_row_t              dir_tab[DIR_ROWS];
  int unsigned           mismatch_cnt = 0;
  bit                    calm = 1'b0;

  char_lcd_nibble_write_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic lcdseq_pkg::out_beat_t ph(input logic [3:0] nib, input logic rs,
                                               input logic en, input logic [15:0] hold,
                                               input logic lst);
    lcdseq_pkg::out_beat_t p;
    p.nibble     = nib;
    p.reg_select = rs;
    p.enable     = en;
    p.hold_us    = hold;
    p.last       = lst;
    return p;
  endfunction

  function automatic dir_row_t mk_row(input logic [1:0] c, input logic [7:0] v,
                                      input logic typed, input lcdseq_pkg::out_beat_t e0,
                                      input lcdseq_pkg::out_beat_t e1,
                                      input lcdseq_pkg::out_beat_t e2,
                                      input lcdseq_pkg::out_beat_t e3);
    dir_row_t r;
    r.beat.cmd        = c;
    r.beat.byte_value = v;
    r.typed           = typed;
    r.want_ph         = {e0, e1, e2, e3};
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 50) $display("ERROR at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_byte(input logic [7:0] v, input logic rs);
    logic [15:0] settle;
    settle = rs ? timing.data_settle_us : timing.command_settle_us;
    pending_phases.push_back(ph(v[7:4], rs, 1'b1, timing.enable_pulse_us, 1'b0));
    pending_phases.push_back(ph(v[7:4], rs, 1'b0, timing.nibble_gap_us, 1'b0));
    pending_phases.push_back(ph(v[3:0], rs, 1'b1, timing.enable_pulse_us, 1'b0));
    pending_phases.push_back(ph(v[3:0], rs, 1'b0, settle, 1'b0));
  endtask

  task automatic predict_phases(input lcdseq_pkg::in_beat_t b);
    lcdseq_pkg::out_beat_t tail;
    case (b.cmd)
      lcdseq_pkg::CMD_WRITE_CMD:  push_byte(b.byte_value, 1'b0);
      lcdseq_pkg::CMD_WRITE_DATA: push_byte(b.byte_value, 1'b1);
      lcdseq_pkg::CMD_CLEAR: begin
        push_byte(lcdseq_pkg::CLEAR_BYTE_0, 1'b0);
        push_byte(lcdseq_pkg::CLEAR_BYTE_1, 1'b0);
      end
      default: begin
        pending_phases.push_back(ph(4'h0, 1'b0, 1'b0, timing.power_on_wait_us, 1'b0));
        for (int i = 0; i < 7; i++) push_byte(lcdseq_pkg::INIT_BYTES[i], 1'b0);
      end
    endcase
    tail      = pending_phases.pop_back();
    tail.last = 1'b1;
    pending_phases.push_back(tail);
  endtask

  task automatic send_req(input lcdseq_pkg::in_beat_t b);
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic rest(input int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle_out();
    in_valid <= 1'b0;
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input lcdseq_pkg::cfg_t t);
    cfg_we    <= 1'b1;
    cfg_index <= lcdseq_pkg::CFG_ENABLE_PULSE;
    cfg_wdata <= t.enable_pulse_us;
    @(posedge clk);
    cfg_index <= lcdseq_pkg::CFG_NIBBLE_GAP;
    cfg_wdata <= t.nibble_gap_us;
    @(posedge clk);
    cfg_index <= lcdseq_pkg::CFG_COMMAND_SETTLE;
    cfg_wdata <= t.command_settle_us;
    @(posedge clk);
    cfg_index <= lcdseq_pkg::CFG_DATA_SETTLE;
    cfg_wdata <= t.data_settle_us;
    @(posedge clk);
    cfg_index <= lcdseq_pkg::CFG_POWER_ON_WAIT;
    cfg_wdata <= t.power_on_wait_us;
    @(posedge clk);
    // A write to an index past the register list must leave every timing value alone.
    cfg_index <= 3'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE));
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    timing = t;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_phases.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = pending_phases.pop_front();
        if (out_beat.nibble !== want.nibble)
          flag_mismatch($sformatf("nibble %h, want %h", out_beat.nibble, want.nibble));
        if (out_beat.reg_select !== want.reg_select)
          flag_mismatch($sformatf("reg_select %b, want %b", out_beat.reg_select,
                                  want.reg_select));
        if (out_beat.enable !== want.enable)
          flag_mismatch($sformatf("enable %b, want %b", out_beat.enable, want.enable));
        if (out_beat.hold_us !== want.hold_us)
          flag_mismatch($sformatf("hold_us %0d, want %0d", out_beat.hold_us, want.hold_us));
        if (out_beat.last !== want.last)
          flag_mismatch($sformatf("last %b, want %b", out_beat.last, want.last));
      end
    end
  end

  initial begin
    int unsigned n;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    lcdseq_pkg::in_beat_t b;
    lcdseq_pkg::cfg_t     t;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_beat   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    dir_tab[0]  = mk_row(lcdseq_pkg::CMD_WRITE_CMD, 8'h00, 1'b1,
                         ph(4'h0, 1'b0, 1'b1, 16'd1, 1'b0), ph(4'h0, 1'b0, 1'b0, 16'd50, 1'b0),
                         ph(4'h0, 1'b0, 1'b1, 16'd1, 1'b0), ph(4'h0, 1'b0, 1'b0, 16'd2000, 1'b1));
    dir_tab[1]  = mk_row(lcdseq_pkg::CMD_WRITE_DATA, 8'hFF, 1'b1,
                         ph(4'hF, 1'b1, 1'b1, 16'd1, 1'b0), ph(4'hF, 1'b1, 1'b0, 16'd50, 1'b0),
                         ph(4'hF, 1'b1, 1'b1, 16'd1, 1'b0), ph(4'hF, 1'b1, 1'b0, 16'd1000, 1'b1));
    dir_tab[2]  = mk_row(lcdseq_pkg::CMD_WRITE_CMD, 8'hFF, 1'b1,
                         ph(4'hF, 1'b0, 1'b1, 16'd1, 1'b0), ph(4'hF, 1'b0, 1'b0, 16'd50, 1'b0),
                         ph(4'hF, 1'b0, 1'b1, 16'd1, 1'b0), ph(4'hF, 1'b0, 1'b0, 16'd2000, 1'b1));
    dir_tab[3]  = mk_row(lcdseq_pkg::CMD_WRITE_DATA, 8'h00, 1'b1,
                         ph(4'h0, 1'b1, 1'b1, 16'd1, 1'b0), ph(4'h0, 1'b1, 1'b0, 16'd50, 1'b0),
                         ph(4'h0, 1'b1, 1'b1, 16'd1, 1'b0), ph(4'h0, 1'b1, 1'b0, 16'd1000, 1'b1));
    dir_tab[4]  = mk_row(lcdseq_pkg::CMD_WRITE_CMD, 8'hA5, 1'b0, '0, '0, '0, '0);
    dir_tab[5]  = mk_row(lcdseq_pkg::CMD_WRITE_DATA, 8'h5A, 1'b0, '0, '0, '0, '0);
    dir_tab[6]  = mk_row(lcdseq_pkg::CMD_CLEAR, 8'h00, 1'b0, '0, '0, '0, '0);
    dir_tab[7]  = mk_row(lcdseq_pkg::CMD_CLEAR, 8'hFF, 1'b0, '0, '0, '0, '0);
    dir_tab[8]  = mk_row(lcdseq_pkg::CMD_INIT, 8'h00, 1'b0, '0, '0, '0, '0);
    dir_tab[9]  = mk_row(lcdseq_pkg::CMD_INIT, 8'hC3, 1'b0, '0, '0, '0, '0);
    dir_tab[10] = mk_row(lcdseq_pkg::CMD_WRITE_DATA, 8'h0F, 1'b0, '0, '0, '0, '0);
    dir_tab[11] = mk_row(lcdseq_pkg::CMD_WRITE_CMD, 8'hF0, 1'b0, '0, '0, '0, '0);

    timing.enable_pulse_us   = 16'd1;
    timing.nibble_gap_us     = 16'd50;
    timing.command_settle_us = 16'd2000;
    timing.data_settle_us    = 16'd1000;
    timing.power_on_wait_us  = 16'd20000;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(dir_tab[i].beat);
      if (dir_tab[i].typed) begin
        for (int k = 0; k < 4; k++) pending_phases.push_back(dir_tab[i].want_ph[k]);
      end else begin
        predict_phases(dir_tab[i].beat);
      end
      rest(gap_len());
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_out();
      case (p)
        0: t = '0;
        1: t = '1;
        2: begin
          t.enable_pulse_us   = 16'hFFFF;
          t.nibble_gap_us     = 16'h0000;
          t.command_settle_us = 16'hFFFF;
          t.data_settle_us    = 16'h0000;
          t.power_on_wait_us  = 16'h0001;
        end
        default: t = lcdseq_pkg::cfg_t'(80'({$urandom, $urandom, $urandom}));
      endcase
      load_timing(t);
      calm = (p == 5);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        b.cmd = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
          0:       b.byte_value = 8'h00;
          1:       b.byte_value = 8'hFF;
          default: b.byte_value = 8'($urandom);
        endcase
        send_req(b);
        predict_phases(b);
        if ($urandom_range(0, 39) == 0) settle_out();
        else rest(gap_len());
      end
    end

    settle_out();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
